### design/bcbi_pkg.sv
package bcbi_pkg;

    // elevation grid in 1/256 degree
    localparam int unsigned STEP_Q8  = 2560;
    localparam int unsigned TOP_Q8   = 23040;
    localparam int unsigned NODES    = 10;
    localparam int unsigned BANDS    = 3;
    // round-to-nearest bias for /2560, and 2^18/5 rounded up for the /5 step
    localparam int unsigned HALF_Q8  = 1280;
    localparam int unsigned RECIP5   = 52429;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_IGSO = 2'd1,
        CLS_MEO  = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        BAND_NONE = 2'd0,
        BAND_B1   = 2'd1,
        BAND_B2   = 2'd2,
        BAND_B3   = 2'd3
    } t_band;

    typedef logic signed [14:0] t_bias;

    typedef struct packed {
        t_class cls;
        logic   err;
    } t_meta;

    typedef struct packed {
        t_bias              t0;
        logic signed [12:0] diff;
        logic [11:0]        off;
        t_meta              meta;
    } t_front;

    // node tables in 0.1 mm
    localparam t_bias IGSO_TAB [BANDS][NODES] = '{
        '{-15'sd5500, -15'sd4000, -15'sd3400, -15'sd2300, -15'sd1500,
          -15'sd400,   15'sd900,   15'sd1900,  15'sd2700,  15'sd3500},
        '{-15'sd7100, -15'sd3600, -15'sd3300, -15'sd1900, -15'sd1400,
          -15'sd300,   15'sd800,   15'sd1700,  15'sd2400,  15'sd3300},
        '{-15'sd2700, -15'sd2300, -15'sd2100, -15'sd1500, -15'sd1100,
          -15'sd400,   15'sd500,   15'sd1400,  15'sd1900,  15'sd3200}
    };

    localparam t_bias MEO_TAB [BANDS][NODES] = '{
        '{-15'sd4700, -15'sd3800, -15'sd3200, -15'sd2300, -15'sd1100,
           15'sd600,   15'sd3400,  15'sd6900,  15'sd9700,  15'sd10500},
        '{-15'sd4000, -15'sd3100, -15'sd2600, -15'sd1800, -15'sd600,
           15'sd900,   15'sd2800,  15'sd4800,  15'sd6400,  15'sd6900},
        '{-15'sd2200, -15'sd1500, -15'sd1300, -15'sd1000, -15'sd400,
           15'sd500,   15'sd1400,  15'sd2700,  15'sd3600,  15'sd4700}
    };

    function automatic t_bias node_val(t_class c, t_band b, logic [3:0] k);
        t_bias v;
        v = '0;
        if (b != BAND_NONE && k < 4'(NODES)) begin
            if (c == CLS_IGSO) begin
                v = IGSO_TAB[2'(b - BAND_B1)][k];
            end else if (c == CLS_MEO) begin
                v = MEO_TAB[2'(b - BAND_B1)][k];
            end
        end
        return v;
    endfunction

endpackage

### design/bcbi_seg_sel.sv
// Class lookup, elevation clamp, segment pick and node fetch.
module bcbi_seg_sel (
    input  logic [5:0]         i_prn,
    input  logic signed [15:0] i_elev,
    input  logic [1:0]         i_band,
    output bcbi_pkg::t_front   o_front
);

    bcbi_pkg::t_class c;
    bcbi_pkg::t_band  b;
    logic [14:0]      e;
    logic [3:0]       seg;
    bcbi_pkg::t_bias  t0;
    bcbi_pkg::t_bias  t1;
    bcbi_pkg::t_bias  dfull;

    always_comb begin
        unique case (i_prn)
            6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd15, 6'd31, 6'd32: c = bcbi_pkg::CLS_IGSO;
            6'd11, 6'd12, 6'd13, 6'd14, 6'd33, 6'd34:            c = bcbi_pkg::CLS_MEO;
            default:                                             c = bcbi_pkg::CLS_NONE;
        endcase
    end

    assign b = bcbi_pkg::t_band'(i_band);

    always_comb begin
        priority if (i_elev < 16'sd0) begin
            e = '0;
        end else if (i_elev > 16'sd23040) begin
            e = 15'(bcbi_pkg::TOP_Q8);
        end else begin
            e = i_elev[14:0];
        end
    end

    // segment = number of interior nodes at or below e, top segment keeps 90 deg
    always_comb begin
        seg = '0;
        for (int k = 1; k <= 8; k++) begin
            if (e >= 15'(k * bcbi_pkg::STEP_Q8)) begin
                seg = seg + 4'd1;
            end
        end
    end

    assign t0    = bcbi_pkg::node_val(c, b, seg);
    assign t1    = bcbi_pkg::node_val(c, b, seg + 4'd1);
    assign dfull = t1 - t0;

    assign o_front.t0       = t0;
    assign o_front.diff     = dfull[12:0];
    assign o_front.off      = 12'(e - 15'(seg) * 15'(bcbi_pkg::STEP_Q8));
    assign o_front.meta.cls = c;
    assign o_front.meta.err = (c != bcbi_pkg::CLS_NONE) && (b == bcbi_pkg::BAND_NONE);

endmodule

### design/bcbi_round.sv
// Signed product / 2560, nearest with ties away from zero, then add the base node.
// /2560 is done as >>9 followed by /5 through a reciprocal multiply.
module bcbi_round (
    input  logic signed [25:0] i_prod,
    input  bcbi_pkg::t_bias    i_t0,
    input  bcbi_pkg::t_meta    i_meta,
    output bcbi_pkg::t_bias    o_bias
);

    logic        neg;
    logic [25:0] mag;
    logic [25:0] sum;
    logic [31:0] scaled;
    logic [13:0] q;
    bcbi_pkg::t_bias sq;

    assign neg    = i_prod[25];
    assign mag    = neg ? 26'(-i_prod) : 26'(i_prod);
    assign sum    = mag + 26'(bcbi_pkg::HALF_Q8);
    assign scaled = 32'(sum[23:9]) * 32'(bcbi_pkg::RECIP5);
    assign q      = scaled[31:18];
    assign sq     = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

    assign o_bias = (i_meta.err || i_meta.cls == bcbi_pkg::CLS_NONE) ? '0 : i_t0 + sq;

endmodule

### design/beidou_code_bias_interp.sv
// BeiDou satellite-induced code bias correction.
//
// Slave stream: one observation per transfer (PRN, elevation in 1/256 deg,
// band in tuser). Master stream: one correction per observation, in order,
// bias in 0.1 mm in tdata, satellite class and band-error flag in tuser.
//
// Pipeline: input register -> product register -> result register.
// An observation passes through the three registers in that order, and its
// result is offered from the result register. One observation is taken
// every cycle while the receiver stays ready, set by the single diff*offset
// multiply stage and the reciprocal-divide stage each holding one item.
//
// Reset (synchronous, active low) clears all stage valids; the input is
// ready right after reset. When the receiver holds tready low the result
// register holds, and the earlier stages keep filling until all three are
// full; only then does o_s_axis_tready drop.
module beidou_code_bias_interp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [5:0] sat_prn, [21:6] elevation_q8, [23:22] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] band
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [14:0] bias_tenth_mm, [15] zero
    output logic [2:0]  o_m_axis_tuser    // [1:0] sat_class, [2] band_error
);

    // stage advance enables, from the back
    logic adv_out;
    logic adv_mid;
    logic adv_in;

    // input register
    logic               r_in_valid;
    logic [5:0]         r_in_prn;
    logic signed [15:0] r_in_elev;
    logic [1:0]         r_in_band;

    // product register
    logic               r_mid_valid;
    logic signed [25:0] r_mid_prod;
    bcbi_pkg::t_bias    r_mid_t0;
    bcbi_pkg::t_meta    r_mid_meta;

    // result register
    logic               r_out_valid;
    bcbi_pkg::t_bias    r_out_bias;
    bcbi_pkg::t_meta    r_out_meta;

    bcbi_pkg::t_front   front;
    logic signed [25:0] n_mid_prod;
    bcbi_pkg::t_bias    n_out_bias;

    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign adv_mid = !r_mid_valid || adv_out;
    assign adv_in  = !r_in_valid  || adv_mid;

    assign o_s_axis_tready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_s_axis_tvalid) begin
            r_in_prn  <= i_s_axis_tdata[5:0];
            r_in_elev <= $signed(i_s_axis_tdata[21:6]);
            r_in_band <= i_s_axis_tuser;
        end
        if (adv_mid && r_in_valid) begin
            r_mid_prod <= n_mid_prod;
            r_mid_t0   <= front.t0;
            r_mid_meta <= front.meta;
        end
        if (adv_out && r_mid_valid) begin
            r_out_bias <= n_out_bias;
            r_out_meta <= r_mid_meta;
        end
    end

    bcbi_seg_sel u_seg (
        .i_prn   (r_in_prn),
        .i_elev  (r_in_elev),
        .i_band  (r_in_band),
        .o_front (front)
    );

    // node difference times offset within the segment
    assign n_mid_prod = front.diff * $signed({1'b0, front.off});

    bcbi_round u_round (
        .i_prod (r_mid_prod),
        .i_t0   (r_mid_t0),
        .i_meta (r_mid_meta),
        .o_bias (n_out_bias)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_bias};
    assign o_m_axis_tuser  = {r_out_meta.err, r_out_meta.cls};

endmodule

### design/bcbi_checker.sv
module bcbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [2:0]  i_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // input only back-pressures when a result is waiting
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid)
        else $error("input stalled with no pending result");

    // uncorrected satellite gives zero, no error flag
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1:0] == bcbi_pkg::CLS_NONE |->
            i_m_tdata == 16'd0 && !i_m_tuser[2])
        else $error("nonzero result for uncorrected satellite");

    // band error only for a corrected satellite, with zero bias
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[2] |->
            i_m_tdata == 16'd0 && i_m_tuser[1:0] != bcbi_pkg::CLS_NONE)
        else $error("bad band-error result");

endmodule

bind beidou_code_bias_interp bcbi_checker u_bcbi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

### bench/beidou_code_bias_interp_test.sv
`timescale 1ns / 100ps

// Checks the BeiDou code bias interpolator against its own predictor.
// The sender pushes observations through the input stream. A monitor pops the
// matching expected correction for each output transfer and compares it field
// by field. The sequence is: directed edge cases, then random traffic with and
// without idling, then a long receiver hold-off that fills the pipe, then more random traffic with idling.
module beidou_code_bias_interp_test;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int IDLE_PCT    = 19;
    localparam int DRAIN_WAIT  = 10;      // pipe is 3 deep; a little margin
    localparam int CYCLE_LIMIT = 200000;

    // Node tables in 0.1 mm, indexed [band-1][node].
    localparam int IGSO_NODE [3][10] = '{
        '{-5500, -4000, -3400, -2300, -1500, -400, 900, 1900, 2700, 3500},
        '{-7100, -3600, -3300, -1900, -1400, -300, 800, 1700, 2400, 3300},
        '{-2700, -2300, -2100, -1500, -1100, -400, 500, 1400, 1900, 3200}
    };
    localparam int MEO_NODE [3][10] = '{
        '{-4700, -3800, -3200, -2300, -1100, 600, 3400, 6900, 9700, 10500},
        '{-4000, -3100, -2600, -1800, -600, 900, 2800, 4800, 6400, 6900},
        '{-2200, -1500, -1300, -1000, -400, 500, 1400, 2700, 3600, 4700}
    };
    // PRNs that get a correction, IGSO first, then MEO.
    localparam logic [5:0] CORRECTED_PRN [14] = '{
        6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd15, 6'd31, 6'd32,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd33, 6'd34
    };

    typedef struct {
        bcbi_pkg::t_bias  bias;
        bcbi_pkg::t_class cls;
        logic             err;
    } t_bias_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;     // [5:0] sat_prn, [21:6] elevation_q8, [23:22] zero
    logic [1:0]  i_s_axis_tuser = '0;     // [1:0] band
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;          // [14:0] bias_tenth_mm, [15] zero
    logic [2:0]  o_m_axis_tuser;          // [1:0] sat_class, [2] band_error

    t_bias_result pending_corr[$];        // corrections owed, oldest first
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;
    int           rx_hold_left = 0;       // cycles of forced receiver hold-off

    beidou_code_bias_interp dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Expected correction: class from the PRN lists, then clamp the elevation,
    // find the 10-degree segment (80..90 covers the top node) and round the
    // interpolated step to nearest, ties away from zero.
    function automatic t_bias_result predict_correction(logic [5:0] prn,
                                                        logic signed [15:0] elev,
                                                        bcbi_pkg::t_band band);
        t_bias_result r;
        int e, seg, off, t0, t1, num, mag, q;
        r.bias = '0;
        r.err  = 1'b0;
        case (prn)
            6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd15, 6'd31, 6'd32: r.cls = bcbi_pkg::CLS_IGSO;
            6'd11, 6'd12, 6'd13, 6'd14, 6'd33, 6'd34:            r.cls = bcbi_pkg::CLS_MEO;
            default:                                  r.cls = bcbi_pkg::CLS_NONE;
        endcase
        if (r.cls != bcbi_pkg::CLS_NONE) begin
            if (band == bcbi_pkg::BAND_NONE) begin
                r.err = 1'b1;
            end else begin
                e = elev;
                if (e < 0) e = 0;
                if (e > 23040) e = 23040;
                seg = e / 2560;
                if (seg > 8) seg = 8;
                off = e - seg * 2560;
                if (r.cls == bcbi_pkg::CLS_IGSO) begin
                    t0 = IGSO_NODE[band - 1][seg];
                    t1 = IGSO_NODE[band - 1][seg + 1];
                end else begin
                    t0 = MEO_NODE[band - 1][seg];
                    t1 = MEO_NODE[band - 1][seg + 1];
                end
                num = (t1 - t0) * off;
                mag = (num < 0) ? -num : num;
                q = (mag + 1280) / 2560;
                if (num < 0) q = -q;
                r.bias = bcbi_pkg::t_bias'(t0 + q);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Receiver: random idling, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Output monitor: every output transfer must match the oldest correction owed.
    always @(posedge i_clk) begin
        t_bias_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_corr.size() == 0) begin
                report_mismatch("unexpected transfer, bias", $signed(o_m_axis_tdata[14:0]), 0);
            end else begin
                want = pending_corr.pop_front();
                if ($signed(o_m_axis_tdata[14:0]) != want.bias)
                    report_mismatch("bias_tenth_mm", $signed(o_m_axis_tdata[14:0]), want.bias);
                if (o_m_axis_tuser[1:0] != want.cls)
                    report_mismatch("sat_class", o_m_axis_tuser[1:0], want.cls);
                if (o_m_axis_tuser[2] != want.err)
                    report_mismatch("band_error", o_m_axis_tuser[2], want.err);
            end
        end
    end

    // One input transfer, with random idle cycles ahead of it.
    task automatic send_obs(logic [5:0] prn, logic signed [15:0] elev, logic [1:0] band);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, elev, prn};
        i_s_axis_tuser  <= band;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_corr.push_back(predict_correction(prn, elev, bcbi_pkg::t_band'(band)));
    endtask

    // Random observation, mostly corrected satellites and in-range elevations;
    // some land on node boundaries or on rounding ties, some use the full field.
    task automatic send_random_obs();
        logic [5:0]         prn;
        logic signed [15:0] elev;
        int                 pick;
        if ($urandom_range(99) < 70)
            prn = CORRECTED_PRN[$urandom_range(13)];
        else
            prn = 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 12)
            elev = 16'($urandom);
        else if (pick < 27)
            elev = 16'($urandom_range(9) * 2560 + $urandom_range(16) - 8);
        else if (pick < 37)
            elev = 16'($urandom_range(8) * 2560 + 8 * ($urandom_range(318) | 1));
        else
            elev = 16'(int'($urandom_range(46080)) - 23040);
        send_obs(prn, elev, 2'($urandom_range(3)));
    endtask

    task automatic test_directed_edges();
        // clamping below zero and above 90 degrees, node hits, top segment
        send_obs(6'd6, 16'sh8000, bcbi_pkg::BAND_B1);
        send_obs(6'd6, -16'sd23040, bcbi_pkg::BAND_B1);
        send_obs(6'd6, -16'sd1, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd0, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd1, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd64, bcbi_pkg::BAND_B1);         // rounding tie
        send_obs(6'd6, 16'sd2560, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd20480, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd23039, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd23040, bcbi_pkg::BAND_B1);      // exactly 90 degrees
        send_obs(6'd6, 16'sd23041, bcbi_pkg::BAND_B1);
        send_obs(6'd6, 16'sd32767, bcbi_pkg::BAND_B1);
        // each class and band
        send_obs(6'd32, 16'sd10000, bcbi_pkg::BAND_B3);
        send_obs(6'd15, 16'sd7688, bcbi_pkg::BAND_B2);
        send_obs(6'd34, 16'sd12808, bcbi_pkg::BAND_B2);
        send_obs(6'd11, 16'sd23040, bcbi_pkg::BAND_B1);
        send_obs(6'd33, 16'sd0, bcbi_pkg::BAND_B3);
        send_obs(6'd12, 16'sd17000, bcbi_pkg::BAND_B2);
        // invalid band on corrected satellites, any band on uncorrected ones
        send_obs(6'd6, 16'sd5000, bcbi_pkg::BAND_NONE);
        send_obs(6'd13, 16'sd5000, bcbi_pkg::BAND_NONE);
        send_obs(6'd0, 16'sd5000, bcbi_pkg::BAND_NONE);
        send_obs(6'd63, 16'sd23040, bcbi_pkg::BAND_B3);
        send_obs(6'd5, 16'sd1000, bcbi_pkg::BAND_B1);
        send_obs(6'd16, -16'sd1000, bcbi_pkg::BAND_B2);
    endtask

    task automatic test_random_idle(int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_random_obs();
    endtask

    // Back-to-back transfers on both sides.
    task automatic test_random_streaming(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_random_obs();
    endtask

    // Receiver holds off long enough that the pipe fills and input stalls.
    task automatic test_backpressure_fill(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        rx_hold_left = 80;
        repeat (count) send_random_obs();
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_idle(400);
        test_random_streaming(300);
        test_backpressure_fill(100);
        test_random_idle(300);

        i_s_axis_tvalid <= 1'b0;
        while (pending_corr.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
design/bcbi_pkg.sv
design/bcbi_seg_sel.sv
design/bcbi_round.sv
design/beidou_code_bias_interp.sv
design/bcbi_checker.sv
bench/beidou_code_bias_interp_test.sv
